FILE: rtl/fan_pwm_curve_hysteresis_defines.svh
// Assertion macros shared by the fan PWM curve RTL.
`ifndef FAN_PWM_CURVE_HYSTERESIS_DEFINES_SVH
`define FAN_PWM_CURVE_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FPCH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define FPCH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fpch_pkg.sv
// Package: widths, codes, types and helpers for the fan PWM curve block.
`timescale 1ns / 1ps
package fpch_pkg;

   localparam int TEMP_W     = 19;   // temperature sample, signed millidegrees
   localparam int PWM_W      = 16;
   localparam int MODE_W     = 2;
   localparam int DEG_W      = 8;
   localparam int POW_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int TGT_W      = 9;    // effective target, -1 .. 254
   localparam int BAND_W     = 9;    // wall - target, 1 .. 255
   localparam int MILLI_W    = 20;   // degrees scaled to millidegrees
   localparam int EXC_W      = 21;   // temp - 1000 * target, signed
   localparam int EXC_MAG_W  = 19;   // positive excess magnitude
   localparam int DEN_W      = 18;   // 1000 * band
   localparam int QUO_W      = 19;   // quotient bound: 65535 * 7 < 2**19
   localparam int NUM_W      = PWM_W + EXC_MAG_W;
   localparam int SPAN_W     = 17;
   localparam int DRV_W      = 22;
   localparam int ON_W       = 24;
   localparam int LIM_W      = 22;
   localparam int CNT_W      = $clog2(QUO_W + 1);

   localparam int MILLI  = 1000;
   localparam int ON_NUM = 3;        // switch-on point: 3/5 of the band
   localparam int ON_DEN = 5;

   localparam logic signed [MILLI_W-1:0] MILLI_S   = MILLI_W'(MILLI);
   localparam logic signed [DRV_W-1:0]   PWM_MAX_S = DRV_W'((1 << PWM_W) - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_TEMP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PWM     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PWM     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER   = 3'd5;

   // operating modes
   localparam logic [MODE_W-1:0] MODE_ONOFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PROP  = 2'd1;

   // register reset values
   localparam logic [MODE_W-1:0] RST_MODE        = MODE_PROP;
   localparam logic [DEG_W-1:0]  RST_TARGET_TEMP = 8'd45;
   localparam logic [DEG_W-1:0]  RST_WALL_TEMP   = 8'd60;
   localparam logic [PWM_W-1:0]  RST_MIN_PWM     = 16'd0;
   localparam logic [PWM_W-1:0]  RST_MAX_PWM     = 16'hFFFF;
   localparam logic [POW_W-1:0]  RST_MAX_POWER   = 3'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DECIDE,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_OFF,
      ACT_FULL,
      ACT_PROP
   } action_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
      logic             rem_nz;
   } div_rsp_type;

   // saturate a signed drive value to the PWM range
   function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [DRV_W-1:0] v);
      logic [PWM_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > PWM_MAX_S) begin
         r = '1;
      end else begin
         r = v[PWM_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/fan_pwm_curve_hysteresis.sv
// Top level: fan PWM curve with hysteresis, temperature in, PWM drive out.
`timescale 1ns / 1ps
`include "fan_pwm_curve_hysteresis_defines.svh"
// Takes one signed temperature sample (millidegrees) per transaction and
// returns the new fan PWM value plus a kick-start flag, one result per
// sample. Mode 0 is on/off with hysteresis, mode 1 proportional above 3/5
// of the target-to-wall band, modes 2 and 3 hold the PWM. A sample is
// taken only while the sequencer is idle. Hold, stop and full-drive
// samples pass the prep, decide and finish states; a proportional one
// also waits in the divide state for the 19-step restoring divider that
// forms span * excess / (1000 * band). The sequencer is ready again in
// the same cycle the result becomes valid, and a waiting result does not
// block the next sample, only its finish. Registers are written through
// csr_write_en / csr_index / csr_wdata, by the user only while the block
// is idle (the block itself does not enforce this); unused indexes are ignored.
module fan_pwm_curve_hysteresis (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fpch_pkg::TEMP_W-1:0]  req_temp_milli,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [fpch_pkg::PWM_W-1:0]   rsp_pwm_value,
   output logic                                rsp_kick_start,
   input  logic                                csr_write_en,
   input  logic        [fpch_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [fpch_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpch_pkg::*;

   // configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [DEG_W-1:0]  target_ff;
   logic [DEG_W-1:0]  wall_ff;
   logic [PWM_W-1:0]  min_pwm_ff;
   logic [PWM_W-1:0]  max_pwm_ff;
   logic [POW_W-1:0]  max_power_ff;

   // sequencer and working registers
   state_type                 state_ff, state_in;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic [PWM_W-1:0]          current_pwm_ff, current_pwm_in;
   logic signed [EXC_W-1:0]   excess_ff, excess_in;
   logic [BAND_W-1:0]         band_ff, band_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic                      hot_ff, hot_in;
   logic                      cold_ff, cold_in;
   logic signed [DRV_W-1:0]   full_drv_ff, full_drv_in;
   logic [PWM_W-1:0]          span_abs_ff, span_abs_in;
   logic                      span_neg_ff, span_neg_in;
   action_type                act_ff, act_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PWM_W-1:0]  rsp_pwm_ff, rsp_pwm_in;
   logic              rsp_kick_ff, rsp_kick_in;

   // sequencer outputs
   logic take_req;
   logic prep_en;
   logic decide_en;
   logic load;
   logic out_free;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // prep stage terms
   logic signed [TGT_W-1:0]   tgt_eff;
   logic signed [MILLI_W-1:0] tgt_milli;
   logic signed [MILLI_W-1:0] wall_milli;
   logic signed [MILLI_W-1:0] temp_x;
   logic signed [SPAN_W-1:0]  span;
   logic signed [DRV_W-1:0]   min_ext;
   logic signed [DRV_W-1:0]   full_prod;

   // decide stage terms
   logic signed [ON_W-1:0]    five_exc;
   logic signed [ON_W-1:0]    on_thr;
   logic [LIM_W-1:0]          full_lim;
   logic                      exc_over;
   logic [NUM_W-1:0]          num;

   // finish stage terms
   logic signed [DRV_W-1:0]   quot_ext;
   logic signed [DRV_W-1:0]   prop_res;
   logic signed [DRV_W-1:0]   prop_drv;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RST_MODE;
         target_ff    <= RST_TARGET_TEMP;
         wall_ff      <= RST_WALL_TEMP;
         min_pwm_ff   <= RST_MIN_PWM;
         max_pwm_ff   <= RST_MAX_PWM;
         max_power_ff <= RST_MAX_POWER;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_TARGET_TEMP: target_ff    <= csr_wdata[DEG_W-1:0];
            CSR_WALL_TEMP:   wall_ff      <= csr_wdata[DEG_W-1:0];
            CSR_MIN_PWM:     min_pwm_ff   <= csr_wdata[PWM_W-1:0];
            CSR_MAX_PWM:     max_pwm_ff   <= csr_wdata[PWM_W-1:0];
            CSR_MAX_POWER:   max_power_ff <= csr_wdata[POW_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = (act_in == ACT_PROP) ? ST_DIV : ST_FIN;
         ST_DIV:    if (div_rsp.done) state_in = ST_FIN;
         ST_FIN:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      prep_en   = 1'b0;
      decide_en = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_PREP:   prep_en   = 1'b1;
         ST_DECIDE: decide_en = 1'b1;
         ST_DIV:    ;
         ST_FIN:    load      = out_free;
         default:   ;
      endcase
   end

   assign take_req = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------ prep stage
   // target at or above wall falls back to wall - 1 (band always >= 1)
   always_comb begin
      tgt_eff     = (target_ff >= wall_ff) ? ($signed({1'b0, wall_ff}) - TGT_W'(1))
                                           : $signed({1'b0, target_ff});
      band_in     = BAND_W'($unsigned($signed({1'b0, wall_ff}) - tgt_eff));
      tgt_milli   = MILLI_W'(tgt_eff) * MILLI_S;
      wall_milli  = $signed(MILLI_W'(wall_ff)) * MILLI_S;
      temp_x      = MILLI_W'(temp_ff);
      hot_in      = temp_x > wall_milli;
      cold_in     = temp_x < tgt_milli;
      excess_in   = EXC_W'(temp_x) - EXC_W'(tgt_milli);
      den_in      = DEN_W'(band_in) * DEN_W'(MILLI);
      span        = $signed({1'b0, max_pwm_ff}) - $signed({1'b0, min_pwm_ff});
      span_neg_in = span[SPAN_W-1];
      span_abs_in = span_neg_in ? PWM_W'(-span) : PWM_W'(span);
      min_ext     = $signed(DRV_W'(min_pwm_ff));
      full_prod   = DRV_W'(span) * $signed(DRV_W'(max_power_ff));
      full_drv_in = min_ext + full_prod;
   end

   // ---------------------------------------------------------- decide stage
   // mode 1 on when 5 * excess > 3000 * band, i.e. above 3/5 of the band
   always_comb begin
      five_exc = ON_W'(excess_ff) * $signed(ON_W'(ON_DEN));
      on_thr   = $signed(ON_W'(band_ff) * ON_W'(ON_NUM * MILLI));
      full_lim = LIM_W'(max_power_ff) * LIM_W'(den_ff);
      exc_over = !excess_ff[EXC_W-1] && (LIM_W'(excess_ff[EXC_W-2:0]) > full_lim);
      num      = NUM_W'(span_abs_ff) * NUM_W'(excess_ff[EXC_MAG_W-1:0]);
      act_in   = ACT_HOLD;
      case (mode_ff)
         MODE_ONOFF: begin
            if (hot_ff) begin
               act_in = ACT_FULL;
            end else if (cold_ff) begin
               act_in = ACT_OFF;
            end
         end
         MODE_PROP: begin
            if (five_exc > on_thr) begin
               act_in = exc_over ? ACT_FULL : ACT_PROP;
            end else if (cold_ff) begin
               act_in = ACT_OFF;
            end
         end
         default: act_in = ACT_HOLD;
      endcase
   end

   assign div_req.start = decide_en && (act_in == ACT_PROP);
   assign div_req.numer = num;
   assign div_req.denom = den_ff;

   fpch_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------- finish stage
   // floor division on a negative span: negate, then step down on remainder
   always_comb begin
      quot_ext = $signed(DRV_W'(div_rsp.quot));
      prop_res = span_neg_ff ? (-quot_ext - $signed(DRV_W'(div_rsp.rem_nz))) : quot_ext;
      prop_drv = $signed(DRV_W'(min_pwm_ff)) + prop_res;
      case (act_ff)
         ACT_OFF:  rsp_pwm_in = '0;
         ACT_FULL: rsp_pwm_in = clamp_pwm(full_drv_ff);
         ACT_PROP: rsp_pwm_in = clamp_pwm(prop_drv);
         default:  rsp_pwm_in = current_pwm_ff;
      endcase
      rsp_kick_in    = ((act_ff == ACT_FULL) || (act_ff == ACT_PROP)) &&
                       (current_pwm_ff == '0);
      current_pwm_in = load ? rsp_pwm_in : current_pwm_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         current_pwm_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         current_pwm_ff <= current_pwm_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (take_req) begin
         temp_ff <= req_temp_milli;
      end
      if (prep_en) begin
         excess_ff   <= excess_in;
         band_ff     <= band_in;
         den_ff      <= den_in;
         hot_ff      <= hot_in;
         cold_ff     <= cold_in;
         full_drv_ff <= full_drv_in;
         span_abs_ff <= span_abs_in;
         span_neg_ff <= span_neg_in;
      end
      if (decide_en) begin
         act_ff <= act_in;
      end
      if (load) begin
         rsp_pwm_ff  <= rsp_pwm_in;
         rsp_kick_ff <= rsp_kick_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pwm_value  = rsp_pwm_ff;
   assign rsp_kick_start = rsp_kick_ff;

   // ------------------------------------------------------------ assertions
   `FPCH_ASSERT_NEXT(a_accept_to_prep, req_valid && req_ready, state_ff == ST_PREP, "accepted sample did not enter prep")
   `FPCH_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `FPCH_ASSERT_NOW(a_rsp_tracks_pwm, rsp_valid_ff, rsp_pwm_ff == current_pwm_ff, "pending result differs from held pwm")
   `FPCH_ASSERT_NEXT(a_off_clears_pwm, load && (act_ff == ACT_OFF), current_pwm_ff == '0, "stop did not clear held pwm")

endmodule

FILE: rtl/fpch_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fpch_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fpch_pkg::div_req_type div_req,
   output fpch_pkg::div_rsp_type div_rsp
);
   import fpch_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   trial;
   logic             ge;

   // quotient is known to fit QUO_W bits, so the top bits start as remainder
   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = DEN_W'(div_req.numer[NUM_W-1:QUO_W]);
         quo_in  = div_req.numer[QUO_W-1:0];
         den_in  = div_req.denom;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quot   = quo_ff;
   assign div_rsp.rem_nz = |rem_ff;

endmodule
